// ===== hw/rtl/csev_pkg.sv =====
`timescale 1ns / 1ps

package csev_pkg;

    // Depth of the coefficient table and the width of its address.
    localparam int MAX_TERMS = 16;
    localparam int C_ADDR_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // Fixed widths of the Q16.16 data path.
    localparam int C_DATA_W = 32;
    localparam int C_TC_W   = 5;
    localparam int C_CFG_W  = 2;

    // Recurrence values saturate to +-(2^47 - 1); the mapped point to 2^62 - 1.
    localparam logic [46:0] C_ACC_CAP = {47{1'b1}};
    localparam logic [61:0] C_Y_CAP   = {62{1'b1}};

    // The divider retires two quotient bits per cycle over a 64-bit dividend.
    localparam int C_DIV_STEPS = 32;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_STEPS);

    // Configuration register indexes.
    localparam logic [C_CFG_W-1:0] CFG_INTERVAL_LOW  = 2'd0;
    localparam logic [C_CFG_W-1:0] CFG_INTERVAL_HIGH = 2'd1;
    localparam logic [C_CFG_W-1:0] CFG_TERM_COUNT    = 2'd2;

    // Input function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [2:0] {
        E_IDLE,
        E_DIV,
        E_MUL,
        E_UPD,
        E_DONE
    } t_state;

    typedef struct packed {
        logic signed [C_DATA_W-1:0] x;
        logic signed [C_DATA_W-1:0] low;
        logic signed [C_DATA_W-1:0] high;
        logic [C_ADDR_W-1:0]        last_index;
    } t_job;

    typedef struct packed {
        logic signed [C_DATA_W-1:0] value;
        logic                       range_error;
    } t_result;

endpackage

// ===== hw/rtl/csev_coef_mem.sv =====
`timescale 1ns / 1ps

module csev_coef_mem (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [csev_pkg::C_ADDR_W-1:0]       i_wr_addr,
    input  logic signed [csev_pkg::C_DATA_W-1:0] i_wr_data,
    input  logic [csev_pkg::C_ADDR_W-1:0]       i_rd_addr,
    output logic signed [csev_pkg::C_DATA_W-1:0] o_rd_data
);

    logic signed [csev_pkg::C_DATA_W-1:0] r_mem [csev_pkg::MAX_TERMS];
    logic signed [csev_pkg::C_DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/csev_engine.sv =====
`timescale 1ns / 1ps

module csev_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  csev_pkg::t_job                       i_job,
    input  logic                                 i_out_free,
    input  logic signed [csev_pkg::C_DATA_W-1:0] i_rd_data,
    output logic [csev_pkg::C_ADDR_W-1:0]        o_rd_addr,
    output logic                                 o_busy,
    output logic                                 o_done,
    output csev_pkg::t_result                    o_result
);

    localparam int L_CW = csev_pkg::C_DIV_CNT_W;
    localparam logic [2:0] L_MUL_LAST = 3'd4;
    localparam logic [109:0] L_ROUND = 110'd1 << 29;
    localparam logic signed [49:0] L_ACC_HI = $signed({3'b000, csev_pkg::C_ACC_CAP});
    localparam logic signed [49:0] L_ACC_LO = -L_ACC_HI;
    localparam logic signed [49:0] L_OUT_HI = 50'sd2147483647;
    localparam logic signed [49:0] L_OUT_LO = -50'sd2147483648;

    csev_pkg::t_state r_state, n_state;
    logic [L_CW-1:0]                     r_cnt, n_cnt;
    logic [31:0]                         r_rem, n_rem;
    logic [63:0]                         r_dvd, n_dvd;
    logic [31:0]                         r_den, n_den;
    logic                                r_yneg, n_yneg;
    logic [61:0]                         r_ymag, n_ymag;
    logic signed [47:0]                  r_d, n_d;
    logic signed [47:0]                  r_dd, n_dd;
    logic [csev_pkg::C_ADDR_W-1:0]       r_j, n_j;
    logic                                r_final, n_final;
    logic [2:0]                          r_step, n_step;
    logic [63:0]                         r_pp, n_pp;
    logic [109:0]                        r_acc, n_acc;
    csev_pkg::t_result                   r_result, n_result;

    logic signed [32:0] w_den;
    logic               w_bad;
    logic signed [34:0] w_num;
    logic [33:0]        w_mag;
    logic [32:0]        w_t1, w_t2;
    logic               w_ge1, w_ge2;
    logic [31:0]        w_r1, w_r2;
    logic [63:0]        w_q;
    logic [62:0]        w_a;
    logic               w_dneg;
    logic [46:0]        w_dmag;
    logic [31:0]        w_op_a, w_op_b;
    logic [1:0]         w_prev;
    logic [109:0]       w_pp_ext;
    logic [46:0]        w_pmag;
    logic signed [49:0] w_sp, w_addend, w_sum;
    logic signed [47:0] w_sat_d;
    logic signed [31:0] w_sat_out;

    // Start-of-job mapping terms: denominator and signed numerator of y.
    always_comb begin
        w_den = 33'(i_job.high) - 33'(i_job.low);
        w_bad = w_den[32] || (w_den == '0);
        w_num = (35'(i_job.x) <<< 1) - 35'(i_job.low) - 35'(i_job.high);
        w_mag = w_num[34] ? 34'(-w_num) : w_num[33:0];
    end

    // Two restoring divide steps per cycle.
    always_comb begin
        w_t1  = {r_rem, r_dvd[63]};
        w_ge1 = w_t1 >= {1'b0, r_den};
        w_r1  = w_ge1 ? 32'(w_t1 - {1'b0, r_den}) : w_t1[31:0];
        w_t2  = {w_r1, r_dvd[62]};
        w_ge2 = w_t2 >= {1'b0, r_den};
        w_r2  = w_ge2 ? 32'(w_t2 - {1'b0, r_den}) : w_t2[31:0];
        w_q   = {r_dvd[61:0], w_ge1, w_ge2};
    end

    // Shared 32x32 multiplier operands; the product is built from four partial products.
    always_comb begin
        w_a    = r_final ? {1'b0, r_ymag} : {r_ymag, 1'b0};
        w_dneg = r_d[47];
        w_dmag = w_dneg ? 47'(-r_d) : r_d[46:0];
        w_op_a = r_step[1] ? {1'b0, w_a[62:32]} : w_a[31:0];
        w_op_b = r_step[0] ? {17'd0, w_dmag[46:32]} : w_dmag[31:0];
        w_prev = 2'(r_step - 3'd1);
        unique case (w_prev)
            2'd0:    w_pp_ext = 110'(r_pp);
            2'd3:    w_pp_ext = 110'(r_pp) << 64;
            default: w_pp_ext = 110'(r_pp) << 32;
        endcase
    end

    // Rounded product, recurrence sum and both saturations.
    always_comb begin
        w_pmag   = (r_acc[109:77] != '0) ? csev_pkg::C_ACC_CAP : r_acc[76:30];
        w_sp     = $signed({3'b000, w_pmag});
        if (r_yneg ^ w_dneg) begin
            w_sp = -w_sp;
        end
        w_addend = r_final ? 50'(i_rd_data >>> 1) : 50'(i_rd_data);
        w_sum    = w_sp - 50'(r_dd) + w_addend;
        if (w_sum > L_ACC_HI) begin
            w_sat_d = 48'(L_ACC_HI);
        end else if (w_sum < L_ACC_LO) begin
            w_sat_d = 48'(L_ACC_LO);
        end else begin
            w_sat_d = w_sum[47:0];
        end
        if (w_sum > L_OUT_HI) begin
            w_sat_out = 32'(L_OUT_HI);
        end else if (w_sum < L_OUT_LO) begin
            w_sat_out = 32'(L_OUT_LO);
        end else begin
            w_sat_out = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csev_pkg::E_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_j     <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_j     <= n_j;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_den    <= n_den;
        r_yneg   <= n_yneg;
        r_ymag   <= n_ymag;
        r_d      <= n_d;
        r_dd     <= n_dd;
        r_pp     <= n_pp;
        r_acc    <= n_acc;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_den    = r_den;
        n_yneg   = r_yneg;
        n_ymag   = r_ymag;
        n_d      = r_d;
        n_dd     = r_dd;
        n_j      = r_j;
        n_final  = r_final;
        n_step   = r_step;
        n_pp     = r_pp;
        n_acc    = r_acc;
        n_result = r_result;
        o_done   = 1'b0;

        unique case (r_state)
            csev_pkg::E_IDLE: begin
                if (i_start) begin
                    if (w_bad) begin
                        n_result.value       = '0;
                        n_result.range_error = 1'b1;
                        n_state              = csev_pkg::E_DONE;
                    end else begin
                        n_den   = w_den[31:0];
                        n_yneg  = w_num[34];
                        n_dvd   = {w_mag, 30'd0};
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_d     = '0;
                        n_dd    = '0;
                        n_j     = i_job.last_index;
                        n_final = (i_job.last_index == '0);
                        n_state = csev_pkg::E_DIV;
                    end
                end
            end
            csev_pkg::E_DIV: begin
                n_rem = w_r2;
                n_dvd = w_q;
                n_cnt = r_cnt + L_CW'(1);
                if (r_cnt == L_CW'(csev_pkg::C_DIV_STEPS - 1)) begin
                    n_ymag  = (w_q[63:62] != 2'b00) ? csev_pkg::C_Y_CAP : w_q[61:0];
                    n_step  = '0;
                    n_state = csev_pkg::E_MUL;
                end
            end
            csev_pkg::E_MUL: begin
                n_pp   = 64'(w_op_a) * 64'(w_op_b);
                n_acc  = (r_step == '0) ? L_ROUND : r_acc + w_pp_ext;
                n_step = r_step + 3'd1;
                if (r_step == L_MUL_LAST) begin
                    n_state = csev_pkg::E_UPD;
                end
            end
            csev_pkg::E_UPD: begin
                if (r_final) begin
                    n_result.value       = w_sat_out;
                    n_result.range_error = 1'b0;
                    n_state              = csev_pkg::E_DONE;
                end else begin
                    n_d     = w_sat_d;
                    n_dd    = r_d;
                    n_final = (r_j == csev_pkg::C_ADDR_W'(1));
                    n_j     = r_j - csev_pkg::C_ADDR_W'(1);
                    n_step  = '0;
                    n_state = csev_pkg::E_MUL;
                end
            end
            csev_pkg::E_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = csev_pkg::E_IDLE;
                end
            end
            default: begin
                n_state = csev_pkg::E_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_j;
    assign o_busy    = (r_state != csev_pkg::E_IDLE);
    assign o_result  = r_result;

endmodule

// ===== hw/rtl/chebyshev_series_evaluator.sv =====
`timescale 1ns / 1ps

// Chebyshev series evaluator using the Clenshaw recurrence, signed Q16.16.
// Input channel (i_in_valid / o_in_ready): a beat with i_func = load writes
// i_data_value into coefficient slot i_coef_index and produces no result; a
// beat with i_func = evaluate maps i_data_value onto [-1, 1] over the
// configured interval and sums the first term_count coefficients (1 to 16).
// Output channel (o_out_valid / i_out_ready): one beat per evaluation carrying
// o_series_value and o_range_error; a bad interval gives value 0, error 1.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
// interval_low, 1 interval_high, 2 term_count; other indexes are dropped.
// An evaluation first runs a radix-4 restoring divider to find the mapped
// point, then for each term the shared 32x32 multiplier forms the product in
// passes and an accumulate step updates the recurrence. A load beat does not
// start the engine, so the input stays open after it.
// The block takes one beat at a time and raises o_in_ready again once the
// result sits in the output register, so the next beat is taken while it waits.
// If the receiver stalls with a result still held, a finished evaluation waits
// inside the engine and input stays blocked until the output register frees.
// Reset (synchronous, active low) restores the interval to [-1, 1] and sixteen
// terms and empties the output register; the coefficient table keeps no reset
// value and each slot used must be loaded before an evaluation reads it.

module chebyshev_series_evaluator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic [3:0]                           i_coef_index,
    input  logic signed [csev_pkg::C_DATA_W-1:0] i_data_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [csev_pkg::C_DATA_W-1:0] o_series_value,
    output logic                                 o_range_error,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [csev_pkg::C_CFG_W-1:0]         i_cfg_index,
    input  logic [csev_pkg::C_DATA_W-1:0]        i_cfg_data
);

    localparam int L_AW = csev_pkg::C_ADDR_W;

    logic signed [csev_pkg::C_DATA_W-1:0] r_low, r_high;
    logic [csev_pkg::C_TC_W-1:0]          r_term_count;
    logic                                 r_out_valid;
    logic signed [csev_pkg::C_DATA_W-1:0] r_series;
    logic                                 r_error;

    logic                                 w_in_accept;
    logic                                 w_cfg_accept;
    logic                                 w_start;
    logic                                 w_load;
    logic                                 w_out_free;
    logic [L_AW-1:0]                      w_last;
    logic [L_AW-1:0]                      w_rd_addr;
    logic signed [csev_pkg::C_DATA_W-1:0] w_rd_data;
    logic                                 w_busy;
    logic                                 w_done;
    csev_pkg::t_job                       w_job;
    csev_pkg::t_result                    w_result;

    assign w_in_accept  = i_in_valid && o_in_ready;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = !w_busy;
    assign w_start      = w_in_accept && (i_func == csev_pkg::FUNC_EVAL);

    // Slots at or beyond the table depth are silently ignored.
    assign w_load = w_in_accept && (i_func == csev_pkg::FUNC_LOAD)
                    && (32'(i_coef_index) < 32'(csev_pkg::MAX_TERMS));

    // The output register frees when empty or when its beat is taken.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Highest coefficient index used: a count of zero acts as one and a
    // count above the table depth is clipped to it.
    always_comb begin
        if (r_term_count == '0) begin
            w_last = '0;
        end else if (32'(r_term_count) > 32'(csev_pkg::MAX_TERMS)) begin
            w_last = L_AW'(csev_pkg::MAX_TERMS - 1);
        end else begin
            w_last = L_AW'(r_term_count - 5'd1);
        end
    end

    always_comb begin
        w_job.x          = i_data_value;
        w_job.low        = r_low;
        w_job.high       = r_high;
        w_job.last_index = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= -32'sd65536;
            r_high       <= 32'sd65536;
            r_term_count <= 5'd16;
        end else if (w_cfg_accept) begin
            unique case (i_cfg_index)
                csev_pkg::CFG_INTERVAL_LOW:  r_low  <= $signed(i_cfg_data);
                csev_pkg::CFG_INTERVAL_HIGH: r_high <= $signed(i_cfg_data);
                csev_pkg::CFG_TERM_COUNT:    r_term_count <= i_cfg_data[csev_pkg::C_TC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_series <= w_result.value;
            r_error  <= w_result.range_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_series_value = r_series;
    assign o_range_error  = r_error;

    csev_coef_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (L_AW'(i_coef_index)),
        .i_wr_data (i_data_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    csev_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_job      (w_job),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_rd_addr  (w_rd_addr),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    // A flagged interval always carries a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_series_value == '0)
        else $error("range error beat with nonzero value");

    // An evaluation occupies the engine, so input closes on the next cycle.
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && (i_func == csev_pkg::FUNC_EVAL) |=> !o_in_ready)
        else $error("input stayed open after an evaluate beat");

    // A load never starts the engine.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && (i_func == csev_pkg::FUNC_LOAD) |=> o_in_ready)
        else $error("load beat blocked the input");

endmodule

// ===== sim/tb_chebyshev_series_evaluator.sv =====
`timescale 1ns / 1ps

// Keeps a bit-exact copy of the evaluator: the coefficient slots, the interval and
// the term count. It also keeps the series values still owed by the block, oldest first.
class clenshaw_scoreboard;

    logic signed [31:0] low_reg   = 32'shFFFF_0000;
    logic signed [31:0] high_reg  = 32'sh0001_0000;
    logic [4:0]         count_reg = 5'd16;
    longint             coef_store [csev_pkg::MAX_TERMS];
    longint             acc_cap   = longint'(csev_pkg::C_ACC_CAP);
    logic [63:0]        y_cap     = 64'(csev_pkg::C_Y_CAP);

    csev_pkg::t_result  pending_sums [$];
    int                 loads       = 0;
    int                 evals       = 0;
    int                 flagged     = 0;
    int                 checked     = 0;
    int                 mismatches  = 0;

    // Multiply a Q16.16 value by the mapped point, which is held as sign plus a Q.30
    // magnitude. The product rounds to nearest with ties away from zero and is
    // clamped to the accumulator range.
    function longint scale_by_y(bit y_neg, logic [63:0] y_mag, longint v);
        logic [63:0]  v_mag;
        logic [127:0] prod;
        logic [127:0] rnd;
        longint       p;
        v_mag = (v < 0) ? 64'(-v) : 64'(v);
        prod  = 128'(y_mag) * 128'(v_mag);
        rnd   = (prod + (128'd1 << 29)) >> 30;
        p     = (rnd > 128'(acc_cap)) ? acc_cap : longint'(rnd[63:0]);
        return (y_neg != (v < 0)) ? -p : p;
    endfunction

    function longint clamp_acc(longint v);
        if (v > acc_cap)
            return acc_cap;
        if (v < -acc_cap)
            return -acc_cap;
        return v;
    endfunction

    // Clenshaw sum at one point under the current register settings.
    function csev_pkg::t_result series_at(logic signed [31:0] point);
        longint            lo;
        longint            hi;
        longint            span;
        longint            num;
        longint            d;
        longint            dd;
        longint            nxt;
        longint            total;
        logic [63:0]       mag;
        logic [63:0]       den;
        logic [63:0]       quo;
        logic [63:0]       rem;
        logic [63:0]       ymag;
        logic [63:0]       y2mag;
        bit                y_neg;
        int                terms;
        int                j;
        csev_pkg::t_result res;
        lo   = longint'(low_reg);
        hi   = longint'(high_reg);
        span = hi - lo;
        if (span <= 0) begin
            res.value       = '0;
            res.range_error = 1'b1;
            return res;
        end
        // The mapped point is (2x - low - high) / (high - low), with the magnitude
        // truncated and then clamped when the whole part overflows.
        num   = 2 * longint'(point) - lo - hi;
        y_neg = (num < 0);
        mag   = y_neg ? 64'(-num) : 64'(num);
        den   = 64'(span);
        quo   = mag / den;
        rem   = mag % den;
        if (quo[63:32] != 32'd0)
            ymag = y_cap;
        else
            ymag = (quo << 30) + ((rem << 30) / den);
        y2mag = ymag << 1;

        // A count of zero acts as one; counts past the table depth use the whole table.
        terms = int'(count_reg);
        if (terms > csev_pkg::MAX_TERMS)
            terms = csev_pkg::MAX_TERMS;
        d  = 0;
        dd = 0;
        for (j = terms - 1; j >= 1; j--) begin
            nxt = clamp_acc(scale_by_y(y_neg, y2mag, d) - dd + coef_store[j]);
            dd  = d;
            d   = nxt;
        end
        total = scale_by_y(y_neg, ymag, d) - dd + (coef_store[0] >>> 1);
        if (total > 64'sd2147483647)
            total = 64'sd2147483647;
        if (total < -64'sd2147483648)
            total = -64'sd2147483648;
        res.value       = total[31:0];
        res.range_error = 1'b0;
        return res;
    endfunction

    function void set_register(logic [csev_pkg::C_CFG_W-1:0] idx, logic [31:0] data);
        case (idx)
            csev_pkg::CFG_INTERVAL_LOW:  low_reg   = data;
            csev_pkg::CFG_INTERVAL_HIGH: high_reg  = data;
            csev_pkg::CFG_TERM_COUNT:    count_reg = data[4:0];
            default: ;
        endcase
    endfunction

    // Called for every accepted input beat.
    function void note_beat(logic op, logic [3:0] idx, logic signed [31:0] value);
        csev_pkg::t_result res;
        if (op == csev_pkg::FUNC_LOAD) begin
            loads++;
            if (int'(idx) < csev_pkg::MAX_TERMS)
                coef_store[idx] = longint'(value);
        end else begin
            evals++;
            res = series_at(value);
            if (res.range_error)
                flagged++;
            pending_sums.push_back(res);
        end
    endfunction

    function void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Called for every accepted output beat.
    function void check_result(logic signed [31:0] value, logic err);
        csev_pkg::t_result want;
        checked++;
        if (pending_sums.size() == 0) begin
            flag_mismatch($sformatf("unrequested result, value %0d error %0b", value, err));
            return;
        end
        want = pending_sums.pop_front();
        if (value !== want.value)
            flag_mismatch($sformatf("series_value expected %0d (%h) got %0d (%h)",
                                    want.value, want.value, value, value));
        if (err !== want.range_error)
            flag_mismatch($sformatf("range_error expected %0b got %0b",
                                    want.range_error, err));
    endfunction

endclass

module tb_chebyshev_series_evaluator;

    localparam int CLK_HALF      = 10;
    // Longer than an evaluation at sixteen terms takes, allowed before touching
    // the registers or ending the run.
    localparam int SETTLE_CYCLES = 200;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SEGMENTS      = 10;
    localparam int SEGMENT_BEATS = 83;
    // The port has room for a fourth index, and the block drops writes to it.
    localparam logic [csev_pkg::C_CFG_W-1:0] CFG_UNUSED = 2'd3;

    logic                                 i_clk      = 1'b0;
    logic                                 i_rst_n    = 1'b0;
    logic                                 in_valid   = 1'b0;
    logic                                 op_bit     = csev_pkg::FUNC_LOAD;
    logic [3:0]                           coef_index = 4'd0;
    logic signed [csev_pkg::C_DATA_W-1:0] data_value = '0;
    logic                                 out_ready  = 1'b0;
    logic                                 cfg_valid  = 1'b0;
    logic [csev_pkg::C_CFG_W-1:0]         cfg_index  = '0;
    logic [csev_pkg::C_DATA_W-1:0]        cfg_data   = '0;

    logic                                 in_ready;
    logic                                 out_valid;
    logic signed [csev_pkg::C_DATA_W-1:0] series_value;
    logic                                 range_error;
    logic                                 cfg_ready;

    int          send_idle_pct    = 19;
    int          recv_idle_pct    = 84;
    int          settings_applied = 0;
    int unsigned cycle_count      = 0;

    clenshaw_scoreboard board = new();

    chebyshev_series_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (op_bit),
        .i_coef_index   (coef_index),
        .i_data_value   (data_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_series_value (series_value),
        .o_range_error  (range_error),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // The receiver stalls at random. Its ready changes only on the falling edge.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            board.check_result(series_value, range_error);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, board.pending_sums.size());
            $display("chebyshev_series_evaluator regression: fail");
            $finish;
        end
    end

    // Present one input beat and return at the edge that takes it. Valid stays high
    // until the next falling edge. There the next beat replaces it, or an idle cycle
    // lowers it, so valid is never lowered and raised again in the same step.
    task automatic send_beat(input logic op, input logic [3:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        op_bit     <= op;
        coef_index <= idx;
        data_value <= value;
        do
            @(posedge i_clk);
        while (!in_ready);
        board.note_beat(op, idx, value);
    endtask

    task automatic write_reg(input logic [csev_pkg::C_CFG_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        board.set_register(idx, value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every owed result. Then allow time for a load beat
    // still in flight, so the block is idle before any register write.
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (board.pending_sums.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        int k;
        // Load every slot before the first evaluation. No read of an unloaded
        // coefficient can happen after this, whatever the term count is.
        // Slots 0 and 1 hold the two extremes.
        for (k = 0; k < csev_pkg::MAX_TERMS; k++)
            send_beat(csev_pkg::FUNC_LOAD, 4'(k),
                      (k == 0) ? 32'h7FFF_FFFF :
                      (k == 1) ? 32'h8000_0000 : 32'(k * 32'h3000) - 32'h0001_8000);

        // Default interval [-1, 1]: the most negative and most positive points
        // drive the mapped point far outside [-1, 1]. The others land at the ends
        // and the middle of the interval.
        send_beat(csev_pkg::FUNC_EVAL, 4'hF, 32'h8000_0000);
        send_beat(csev_pkg::FUNC_EVAL, 4'h0, 32'h7FFF_FFFF);
        send_beat(csev_pkg::FUNC_EVAL, 4'hA, 32'h0000_0000);
        send_beat(csev_pkg::FUNC_EVAL, 4'h5, 32'hFFFF_0000);
        send_beat(csev_pkg::FUNC_EVAL, 4'h3, 32'h0001_0000);

        // An empty interval is an error. The write to the unused index must
        // change nothing.
        drain_results();
        write_reg(csev_pkg::CFG_INTERVAL_LOW, 32'h0000_0000);
        write_reg(csev_pkg::CFG_INTERVAL_HIGH, 32'h0000_0000);
        write_reg(CFG_UNUSED, $urandom);
        settings_applied++;
        send_beat(csev_pkg::FUNC_EVAL, 4'h0, 32'h0001_0000);

        // An inverted interval with the ends at the extremes is also an error.
        drain_results();
        write_reg(csev_pkg::CFG_INTERVAL_LOW, 32'h7FFF_FFFF);
        write_reg(csev_pkg::CFG_INTERVAL_HIGH, 32'h8000_0000);
        settings_applied++;
        send_beat(csev_pkg::FUNC_EVAL, 4'h0, 32'h0000_0000);

        // The widest legal interval with a term count of zero, which uses c0 alone.
        drain_results();
        write_reg(csev_pkg::CFG_INTERVAL_LOW, 32'h8000_0000);
        write_reg(csev_pkg::CFG_INTERVAL_HIGH, 32'h7FFF_FFFF);
        write_reg(csev_pkg::CFG_TERM_COUNT, 32'd0);
        settings_applied++;
        send_beat(csev_pkg::FUNC_EVAL, 4'h9, 32'h7FFF_FFFF);

        // A term count past the table depth uses the whole table.
        drain_results();
        write_reg(csev_pkg::CFG_INTERVAL_LOW, 32'hFFFF_0000);
        write_reg(csev_pkg::CFG_INTERVAL_HIGH, 32'h0001_0000);
        write_reg(csev_pkg::CFG_TERM_COUNT, 32'd31);
        settings_applied++;
        send_beat(csev_pkg::FUNC_EVAL, 4'h1, 32'h0000_8000);

        drain_results();
        write_reg(csev_pkg::CFG_TERM_COUNT, 32'd1);
        settings_applied++;
        send_beat(csev_pkg::FUNC_EVAL, 4'h6, 32'h1234_5678);
    endtask

    // Drain, then pick a new interval and term count. Most intervals are small
    // and well formed. A few are extreme, fully random, or deliberately empty.
    task automatic new_setting();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tc;
        int          kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
        end else if (kind == 1) begin
            lo = 32'($urandom_range(1 << 20));
            hi = lo - 32'($urandom_range(1 << 16));
        end else if (kind == 2) begin
            lo = $urandom;
            hi = $urandom;
        end else begin
            lo = 32'($urandom_range(1 << 20)) - 32'(1 << 19);
            hi = lo + 32'($urandom_range(1 << 20, 1));
        end
        tc = ($urandom_range(7) == 0) ? 32'($urandom_range(31)) : 32'($urandom_range(16, 1));
        // The block must ignore the unused upper bits of the term count write.
        if ($urandom_range(1) == 1)
            tc = tc | ($urandom & 32'hFFFF_FFE0);
        drain_results();
        write_reg(csev_pkg::CFG_INTERVAL_LOW, lo);
        write_reg(csev_pkg::CFG_INTERVAL_HIGH, hi);
        write_reg(csev_pkg::CFG_TERM_COUNT, tc);
        settings_applied++;
    endtask

    // About three beats in ten reload a coefficient. The rest evaluate at a
    // point, mostly inside the current interval.
    task automatic random_beat();
        longint      lo;
        longint      hi;
        logic [63:0] span;
        logic [31:0] value;
        int          pick;
        lo = longint'(board.low_reg);
        hi = longint'(board.high_reg);
        if ($urandom_range(99) < 30) begin
            pick = $urandom_range(9);
            if (pick < 7)
                value = 32'($urandom_range(1 << 19)) - 32'(1 << 18);
            else if (pick < 9)
                value = $urandom;
            else
                value = ($urandom_range(1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            send_beat(csev_pkg::FUNC_LOAD, 4'($urandom_range(15)), value);
        end else begin
            pick = $urandom_range(9);
            if (hi > lo && pick < 6) begin
                span  = 64'(hi - lo) + 64'd1;
                value = 32'(lo + longint'({$urandom, $urandom} % span));
            end else if (hi > lo && pick == 6) begin
                if ($urandom_range(1) == 1)
                    value = 32'(hi + longint'($urandom_range(1 << 18, 1)));
                else
                    value = 32'(lo - longint'($urandom_range(1 << 18, 1)));
            end else if (pick == 7) begin
                value = ($urandom_range(1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
                value = $urandom;
            end
            send_beat(csev_pkg::FUNC_EVAL, 4'($urandom), value);
        end
    endtask

    initial begin
        int seg;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // The first four segments have a slow receiver, the next three a slow sender,
        // and the last three run at full rate on both sides.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 4) begin
                send_idle_pct = 84;
                recv_idle_pct = 19;
            end
            if (seg == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            new_setting();
            repeat (SEGMENT_BEATS) random_beat();
        end

        drain_results();

        $display("Ran %0d coefficient loads and %0d evaluations (%0d with a bad interval)",
                 board.loads, board.evals, board.flagged);
        $display("over %0d register settings; %0d results checked, %0d mismatches.",
                 settings_applied, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_sums.size() == 0)
            $display("chebyshev_series_evaluator regression: pass");
        else
            $display("chebyshev_series_evaluator regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/csev_pkg.sv
hw/rtl/csev_coef_mem.sv
hw/rtl/csev_engine.sv
hw/rtl/chebyshev_series_evaluator.sv
sim/tb_chebyshev_series_evaluator.sv
